>>> hw/rtl/lz4d_pkg.sv
// Package for the LZ4 block decompressor: constants, decode phases and the
// queue item type. No dependencies.
package lz4d_pkg;

   localparam int HISTORY_DEPTH = 65536;
   localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
   localparam int SIZE_W        = 24;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

   localparam logic [SIZE_W-1:0] MAX24      = {SIZE_W{1'b1}};
   localparam int                ML_BITS    = 4;
   localparam int                LIT_SHIFT  = 8 - ML_BITS;
   localparam logic [3:0]        NIB_ESC    = 4'd15;
   localparam logic [7:0]        EXT_MORE   = 8'd255;
   localparam logic [2:0]        MIN_MATCH  = 3'd4;
   localparam logic [3:0]        END_MARGIN = 4'd8;

   typedef enum logic [2:0] {
      PH_TOKEN, PH_LITEXT, PH_LITERAL, PH_OFFLO,
      PH_OFFHI, PH_MATCHEXT, PH_COPY, PH_HALT
   } phase_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] in_byte;
   } req_item_type;

endpackage

>>> hw/rtl/lz4d_if.sv
// Channel interfaces of the LZ4 block decompressor: request, response and
// configuration write. Depends on lz4d_pkg for widths.
interface lz4d_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] in_byte;
   modport source (output valid, req_type, in_byte, input ready);
   modport sink   (input valid, req_type, in_byte, output ready);
endinterface

interface lz4d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_last;
   logic       bad_offset;
   modport source (output valid, out_byte, is_last, bad_offset, input ready);
   modport sink   (input valid, out_byte, is_last, bad_offset, output ready);
endinterface

interface lz4d_csr_if import lz4d_pkg::*;;
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] output_size;
   modport source (output valid, output_size, input ready);
   modport sink   (input valid, output_size, output ready);
endinterface

>>> hw/rtl/lz4d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lz4d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/lz4d_front.sv
// Front of the LZ4 block decompressor: accepts request transfers into a
// short queue ahead of the decoder. Depends on lz4d_pkg and lz4d_if.
module lz4d_front import lz4d_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   lz4d_req_if.sink     req_ch,
   output logic         q_valid,
   input  logic         q_ready,
   output req_item_type q_item
);
   req_item_type        slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                push, pop;

   assign req_ch.ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (count_ff != '0);
   assign pop          = q_valid && q_ready;
   assign q_item       = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{req_type: req_ch.req_type, in_byte: req_ch.in_byte};
      end
   end
endmodule

>>> hw/rtl/lz4d_back.sv
// Back of the LZ4 block decompressor: sequence decoder, history RAM with
// a forwarded write-back stage, and the response register.
// Depends on lz4d_pkg, lz4d_if and lz4d_ram.
module lz4d_back import lz4d_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [SIZE_W-1:0] output_size,
   input  logic              q_valid,
   output logic              q_ready,
   input  req_item_type      q_item,
   lz4d_rsp_if.source        rsp_ch
);
   phase_type          phase_ff, phase_in;
   logic [3:0]         nib_ff, nib_in;
   logic [SIZE_W-1:0]  run_ff, run_in;
   logic [15:0]        dist_ff, dist_in;
   logic [SIZE_W-1:0]  prod_ff, prod_in;

   logic               b_res_ff, b_res_in;
   logic               b_wr_ff, b_wr_in;
   logic               b_copy_ff, b_copy_in;
   logic               b_fwd_ff, b_fwd_in;
   logic [HIST_AW-1:0] b_wa_ff, b_wa_in;
   logic [7:0]         b_byte_ff, b_byte_in;
   logic               b_last_ff, b_last_in;
   logic               b_bad_ff, b_bad_in;
   logic [7:0]         prev_ff;

   logic               rsp_valid_ff;
   logic [7:0]         rsp_byte_ff;
   logic               rsp_last_ff, rsp_bad_ff;

   logic               adv, take, fin, bad;
   logic [HIST_AW-1:0] src;
   logic [7:0]         ram_rd, b_data;
   logic [SIZE_W:0]    sum1, sum2;
   logic [SIZE_W+1:0]  end_pos;
   logic [SIZE_W-1:0]  run_dec, prod_inc, sat1;
   logic [16:0]        avail;
   logic [15:0]        dist_full;

   assign adv     = !rsp_valid_ff || rsp_ch.ready;
   assign q_ready = adv;
   assign take    = q_valid && adv;

   assign src      = prod_ff[HIST_AW-1:0] - dist_ff[HIST_AW-1:0];
   assign end_pos  = {2'b00, prod_ff} + {2'b00, run_ff} + (SIZE_W+2)'(END_MARGIN);
   assign fin      = end_pos > {2'b00, output_size};
   assign run_dec  = run_ff - 1'b1;
   assign prod_inc = (prod_ff == MAX24) ? prod_ff : prod_ff + 1'b1;
   assign sum1     = {1'b0, run_ff} + {{(SIZE_W-7){1'b0}}, q_item.in_byte};
   assign sat1     = sum1[SIZE_W] ? MAX24 : sum1[SIZE_W-1:0];
   assign sum2     = {1'b0, sat1} + (SIZE_W+1)'(MIN_MATCH);
   assign dist_full = {q_item.in_byte, dist_ff[7:0]};
   assign avail    = (prod_ff > SIZE_W'(HISTORY_DEPTH)) ? 17'(HISTORY_DEPTH)
                                                       : prod_ff[16:0];
   assign bad      = (dist_full == '0) || ({1'b0, dist_full} > avail);

   always_comb begin
      phase_in  = phase_ff;
      nib_in    = nib_ff;
      run_in    = run_ff;
      dist_in   = dist_ff;
      prod_in   = prod_ff;
      b_res_in  = 1'b0;
      b_wr_in   = 1'b0;
      b_copy_in = 1'b0;
      b_fwd_in  = b_wr_ff && (b_wa_ff == src);
      b_wa_in   = prod_ff[HIST_AW-1:0];
      b_byte_in = q_item.in_byte;
      b_last_in = 1'b0;
      b_bad_in  = 1'b0;
      if (take && phase_ff != PH_HALT) begin
         if (q_item.req_type) begin
            if (phase_ff == PH_COPY) begin
               b_res_in  = 1'b1;
               b_wr_in   = 1'b1;
               b_copy_in = 1'b1;
               prod_in   = prod_inc;
               run_in    = (run_ff != '0) ? run_dec : run_ff;
               if (run_in == '0) begin
                  phase_in = PH_TOKEN;
               end
            end
         end else begin
            case (phase_ff)
               PH_TOKEN: begin
                  nib_in = q_item.in_byte[3:0];
                  run_in = SIZE_W'(q_item.in_byte >> LIT_SHIFT);
                  if (run_in == SIZE_W'(NIB_ESC)) begin
                     phase_in = PH_LITEXT;
                  end else if (run_in != '0) begin
                     phase_in = PH_LITERAL;
                  end else begin
                     phase_in = ({2'b00, prod_ff} + (SIZE_W+2)'(END_MARGIN)
                                 > {2'b00, output_size}) ? PH_HALT : PH_OFFLO;
                  end
               end
               PH_LITEXT: begin
                  run_in = sat1;
                  if (q_item.in_byte != EXT_MORE) begin
                     if (sat1 != '0) begin
                        phase_in = PH_LITERAL;
                     end else begin
                        phase_in = fin ? PH_HALT : PH_OFFLO;
                     end
                  end
               end
               PH_LITERAL: begin
                  b_res_in  = 1'b1;
                  b_wr_in   = 1'b1;
                  prod_in   = prod_inc;
                  run_in    = run_dec;
                  b_last_in = fin && (run_dec == '0);
                  if (run_dec == '0) begin
                     phase_in = fin ? PH_HALT : PH_OFFLO;
                  end
               end
               PH_OFFLO: begin
                  dist_in  = {8'h00, q_item.in_byte};
                  phase_in = PH_OFFHI;
               end
               PH_OFFHI: begin
                  dist_in = dist_full;
                  if (bad) begin
                     phase_in  = PH_HALT;
                     b_res_in  = 1'b1;
                     b_bad_in  = 1'b1;
                     b_byte_in = '0;
                  end else if (nib_ff == NIB_ESC) begin
                     run_in   = SIZE_W'(NIB_ESC);
                     phase_in = PH_MATCHEXT;
                  end else begin
                     run_in   = SIZE_W'(nib_ff) + SIZE_W'(MIN_MATCH);
                     phase_in = PH_COPY;
                  end
               end
               PH_MATCHEXT: begin
                  run_in = sat1;
                  if (q_item.in_byte != EXT_MORE) begin
                     run_in   = sum2[SIZE_W] ? MAX24 : sum2[SIZE_W-1:0];
                     phase_in = PH_COPY;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   lz4d_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
      .clock   (clock),
      .wr_en   (adv && b_wr_ff),
      .wr_addr (b_wa_ff),
      .wr_data (b_data),
      .rd_en   (adv),
      .rd_addr (src),
      .rd_data (ram_rd)
   );

   assign b_data = b_copy_ff ? (b_fwd_ff ? prev_ff : ram_rd) : b_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TOKEN;
         nib_ff       <= '0;
         run_ff       <= '0;
         dist_ff      <= '0;
         prod_ff      <= '0;
         b_res_ff     <= 1'b0;
         b_wr_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         phase_ff     <= phase_in;
         nib_ff       <= nib_in;
         run_ff       <= run_in;
         dist_ff      <= dist_in;
         prod_ff      <= prod_in;
         b_res_ff     <= b_res_in;
         b_wr_ff      <= b_wr_in;
         rsp_valid_ff <= b_res_ff;
      end
      if (adv) begin
         b_copy_ff   <= b_copy_in;
         b_fwd_ff    <= b_fwd_in;
         b_wa_ff     <= b_wa_in;
         b_byte_ff   <= b_byte_in;
         b_last_ff   <= b_last_in;
         b_bad_ff    <= b_bad_in;
         rsp_byte_ff <= b_data;
         rsp_last_ff <= b_last_ff;
         rsp_bad_ff  <= b_bad_ff;
         if (b_wr_ff) begin
            prev_ff <= b_data;
         end
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_byte   = rsp_byte_ff;
   assign rsp_ch.is_last    = rsp_last_ff;
   assign rsp_ch.bad_offset = rsp_bad_ff;
endmodule

>>> hw/rtl/lz4_block_decompressor.sv
// Top level of the LZ4 block decompressor: front queue, back decoder and
// output_size register. Depends on lz4d_pkg, lz4d_if, lz4d_front, lz4d_back.
//
//   channel  dir  payload                          transfer
//   req_ch   in   req_type, in_byte                valid & ready
//   rsp_ch   out  out_byte, is_last, bad_offset    valid & ready
//   csr_ch   in   output_size                      valid & ready
//
// One request per cycle while no response stalls; a response passes from its
// request transfer through the queue, decode and RAM read, and response register.
// Match bytes at distance one come from the write-back stage, not the RAM.
// Reset is synchronous; the history RAM is not cleared.
// A stalled response holds the whole back part; the two-entry queue absorbs it.
module lz4_block_decompressor import lz4d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lz4d_req_if.sink   req_ch,
   lz4d_rsp_if.source rsp_ch,
   lz4d_csr_if.sink   csr_ch
);
   logic [SIZE_W-1:0] output_size_ff;
   logic              q_valid, q_ready;
   req_item_type      q_item;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_size_ff <= '0;
      end else if (csr_ch.valid) begin
         output_size_ff <= csr_ch.output_size;
      end
   end

   lz4d_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_item  (q_item)
   );

   lz4d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .output_size (output_size_ff),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_item      (q_item),
      .rsp_ch      (rsp_ch)
   );
endmodule

>>> hw/rtl/lz4d_chk.sv
// Port checker for the LZ4 block decompressor and its bind to the top level.
// Depends on lz4_block_decompressor.
module lz4d_chk (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_is_last,
   input logic       rsp_bad_offset
);
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("response dropped during stall");

   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_offset |-> rsp_out_byte == 8'h00 && !rsp_is_last)
      else $error("bad offset response carries data");

   a_end_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_is_last || rsp_bad_offset) |=> !rsp_valid)
      else $error("response after end of block");

   a_end_quiet2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_is_last || rsp_bad_offset) |=> ##1 !rsp_valid)
      else $error("response after end of block");
endmodule

bind lz4_block_decompressor lz4d_chk u_chk (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_byte   (rsp_ch.out_byte),
   .rsp_is_last    (rsp_ch.is_last),
   .rsp_bad_offset (rsp_ch.bad_offset)
);
